### design/mvtd_pkg.sv
`timescale 1ns / 1ps

package mvtd_pkg;

  // channel count and derived widths
  localparam int NUM_CHANNELS = 8;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int MASK_N       = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;

  localparam logic [10:0]        RELOAD_RESET = 11'd1024;
  localparam logic [10:0]        OPEN_RATE    = 11'd2;
  localparam logic signed [11:0] COUNT_IDLE   = -12'sd1;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_OPEN  = 3'd1,
    CMD_CLOSE = 3'd2,
    CMD_RATE  = 3'd3,
    CMD_ACK   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_RATE  = 2'd1,
    ST_NOT_READY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_CMD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  channel;
    logic [15:0] freq_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] event_mask;
  } out_item_t;

  // one memory word per channel
  typedef struct packed {
    logic [10:0]        rate;
    logic signed [11:0] count;
  } chan_word_t;

endpackage

### design/mvtd_out_reg.sv
`timescale 1ns / 1ps

module mvtd_out_reg import mvtd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t load_item,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // free when empty or being drained this cycle
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= load_item;
    end
  end

endmodule

### design/multichannel_virtual_tick_divider.sv
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------
// in       | in_valid / in_ready  | in_item  (cmd, channel, freq_value)
// out      | out_valid / out_ready| out_item (status, event_mask)
// cfg      | cfg_valid / cfg_ready| cfg_data (reload_count, 11 bits)
//
// a tick request sweeps every entry through the
// single read port of the channel memory: one entry is read, updated and written back per cycle
// open, close, set rate and acknowledge pass through accept, read-modify-write and result
// sync reset: all channels closed, flags clear, reload 1024; memory entries read as
// rate 0 / count -1 until first written (per-entry written bits)
// a waiting result does not block acceptance of the next request; the sequencer only
// stalls in its result state while the output register is still full

module multichannel_virtual_tick_divider import mvtd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  state_t state, state_next;

  // latched request and config
  in_item_t    req;
  logic [10:0] reload;

  // per-channel control bits kept in flops, rate and count live in the memory
  logic [NUM_CHANNELS-1:0] chan_open;
  logic [NUM_CHANNELS-1:0] chan_flag;
  logic [NUM_CHANNELS-1:0] chan_written;

  chan_word_t mem [NUM_CHANNELS];
  chan_word_t rd_word;
  logic       rd_written;
  chan_word_t cur;

  logic             mem_re;
  logic [CH_W-1:0]  rd_addr;
  logic             mem_we;
  logic [CH_W-1:0]  wr_addr;
  chan_word_t       wr_word;

  logic [CH_W-1:0] tick_idx;
  logic            tick_last;
  logic [CH_W-1:0] in_ch;
  logic            in_in_range;
  logic            in_is_chan_cmd;
  logic [CH_W-1:0] req_ch;
  logic            rate_ok;
  logic            in_take;

  status_t   status;
  logic      res_free;
  logic      res_load;
  out_item_t res_item;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && in_ready;

  assign in_ch          = CH_W'(in_item.channel);
  assign in_in_range    = int'(in_item.channel) < NUM_CHANNELS;
  assign in_is_chan_cmd = (in_item.cmd == CMD_OPEN) || (in_item.cmd == CMD_CLOSE) ||
                          (in_item.cmd == CMD_RATE) || (in_item.cmd == CMD_ACK);
  assign req_ch         = CH_W'(req.channel);
  assign tick_last      = tick_idx == CH_W'(NUM_CHANNELS - 1);

  // powers of two from 2 to 1024 only
  assign rate_ok = $onehot(req.freq_value) && !req.freq_value[0] &&
                   (req.freq_value[15:11] == 5'd0);

  // never-written entries read as their reset value
  always_comb begin
    if (rd_written) begin
      cur = rd_word;
    end else begin
      cur.rate  = 11'd0;
      cur.count = COUNT_IDLE;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          if (in_item.cmd == CMD_TICK) begin
            state_next = S_TICK;
          end else if (in_in_range && in_is_chan_cmd) begin
            state_next = S_CMD;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_TICK: begin
        if (tick_last) begin
          state_next = S_RESP;
        end
      end
      S_CMD: state_next = S_RESP;
      S_RESP: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: memory port control and write data
  always_comb begin
    in_ready = 1'b0;
    mem_re   = 1'b0;
    rd_addr  = '0;
    mem_we   = 1'b0;
    wr_addr  = '0;
    wr_word  = cur;
    res_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        mem_re   = in_take;
        rd_addr  = (in_item.cmd == CMD_TICK) ? '0 : in_ch;
      end
      S_TICK: begin
        // read next entry while writing back the current one
        mem_re        = !tick_last;
        rd_addr       = CH_W'(tick_idx + 1'b1);
        wr_addr       = tick_idx;
        mem_we        = chan_open[tick_idx] && (cur.count > 12'sd0);
        wr_word.count = cur.count - $signed({1'b0, cur.rate});
      end
      S_CMD: begin
        wr_addr = req_ch;
        unique case (req.cmd)
          CMD_OPEN: begin
            mem_we        = 1'b1;
            wr_word.rate  = OPEN_RATE;
            wr_word.count = $signed({1'b0, reload});
          end
          CMD_CLOSE: begin
            mem_we        = 1'b1;
            wr_word.count = COUNT_IDLE;
          end
          CMD_RATE: begin
            mem_we       = rate_ok;
            wr_word.rate = req.freq_value[10:0];
          end
          CMD_ACK: begin
            mem_we        = chan_flag[req_ch];
            wr_word.count = $signed({1'b0, reload});
          end
          default: mem_we = 1'b0;
        endcase
      end
      S_RESP: res_load = res_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload <= RELOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      reload <= cfg_data;
    end
  end

  // channel memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_word;
    end
    if (mem_re) begin
      rd_word    <= mem[rd_addr];
      rd_written <= chan_written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_idx <= '0;
    end else if (in_take) begin
      tick_idx <= '0;
    end else if (state == S_TICK && !tick_last) begin
      tick_idx <= CH_W'(tick_idx + 1'b1);
    end
  end

  // open, flag and written bits, plus the status of the request in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_open    <= '0;
      chan_flag    <= '0;
      chan_written <= '0;
      status       <= ST_DONE;
    end else begin
      if (in_take) begin
        status <= ST_DONE;
      end
      if (mem_we) begin
        chan_written[wr_addr] <= 1'b1;
      end
      if (state == S_TICK) begin
        // expired open channel raises its event
        if (chan_open[tick_idx] && !(cur.count > 12'sd0)) begin
          chan_flag[tick_idx] <= 1'b1;
        end
      end else if (state == S_CMD) begin
        unique case (req.cmd)
          CMD_OPEN: begin
            chan_open[req_ch] <= 1'b1;
            chan_flag[req_ch] <= 1'b0;
          end
          CMD_CLOSE: begin
            chan_open[req_ch] <= 1'b0;
            chan_flag[req_ch] <= 1'b0;
          end
          CMD_RATE: begin
            if (rate_ok) begin
              chan_open[req_ch] <= 1'b1;
            end else begin
              status <= ST_BAD_RATE;
            end
          end
          CMD_ACK: begin
            if (chan_flag[req_ch]) begin
              chan_flag[req_ch] <= 1'b0;
            end else begin
              status <= ST_NOT_READY;
            end
          end
          default: status <= ST_DONE;
        endcase
      end
    end
  end

  // result: status and flags as they stand after the request
  always_comb begin
    res_item.status     = status;
    res_item.event_mask = '0;
    for (int i = 0; i < MASK_N; i++) begin
      res_item.event_mask[i] = chan_flag[i];
    end
  end

  mvtd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .load_item (res_item),
    .free      (res_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // memory is only written by the sweep or a channel command
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_TICK || state == S_CMD))
    else $error("memory write outside sweep or command");

  // the sweep steps one entry per cycle
  a_sweep_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK && !tick_last) |=> (tick_idx == CH_W'($past(tick_idx) + 1'b1)))
    else $error("tick sweep skipped an entry");

  // a channel command moves from its read-modify-write state straight to the result state
  a_cmd_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMD) |=> (state == S_RESP))
    else $error("command did not reach result state");

  // a sweep read never targets the entry being written back
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (rd_addr != wr_addr))
    else $error("read and write of the same entry in one cycle");

endmodule

### dv/multichannel_virtual_tick_divider_tb.sv
`timescale 1ns / 1ps

module multichannel_virtual_tick_divider_tb;
  import mvtd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 10;
  // command codes the block has no use for
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOPPY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  // own copy of the channel table and the reload register
  logic [10:0]        reload_q;
  logic               ch_open  [NUM_CHANNELS];
  logic [10:0]        ch_rate  [NUM_CHANNELS];
  logic signed [11:0] ch_count [NUM_CHANNELS];
  logic               ch_flag  [NUM_CHANNELS];

  out_item_t status_owed[$];
  int        errors = 0;
  int        cycle_count = 0;
  rx_mode_t  rx_mode = RX_OPEN;
  int        rx_left = 0;

  multichannel_virtual_tick_divider i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("multichannel_virtual_tick_divider_tb: done, errors");
      $finish;
    end
  end

  function automatic in_item_t make_req(logic [2:0] cmd, logic [2:0] ch, logic [15:0] freq);
    in_item_t r;
    r.cmd        = cmd;
    r.channel    = ch;
    r.freq_value = freq;
    return r;
  endfunction

  // applies one request to the channel table, returns status and flags after it
  function automatic out_item_t apply_request(in_item_t r);
    out_item_t res;
    int        c;
    int        f;
    res.status     = ST_DONE;
    res.event_mask = '0;
    c = r.channel;
    f = r.freq_value;
    if (r.cmd == CMD_TICK) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (ch_open[i]) begin
          if (ch_count[i] > 0) ch_count[i] = ch_count[i] - $signed({1'b0, ch_rate[i]});
          else ch_flag[i] = 1'b1;
        end
      end
    end else if (c < NUM_CHANNELS) begin
      case (r.cmd)
        CMD_OPEN: begin
          ch_open[c]  = 1'b1;
          ch_rate[c]  = OPEN_RATE;
          ch_count[c] = $signed({1'b0, reload_q});
          ch_flag[c]  = 1'b0;
        end
        CMD_CLOSE: begin
          ch_open[c]  = 1'b0;
          ch_count[c] = COUNT_IDLE;
          ch_flag[c]  = 1'b0;
        end
        CMD_RATE: begin
          if (f >= 2 && f <= 1024 && (f & (f - 1)) == 0) begin
            ch_rate[c] = f[10:0];
            ch_open[c] = 1'b1;
          end else begin
            res.status = ST_BAD_RATE;
          end
        end
        CMD_ACK: begin
          if (ch_flag[c]) begin
            ch_flag[c]  = 1'b0;
            ch_count[c] = $signed({1'b0, reload_q});
          end else begin
            res.status = ST_NOT_READY;
          end
        end
        default: ;
      endcase
    end
    for (int i = 0; i < MASK_N; i++) res.event_mask[i] = ch_flag[i];
    return res;
  endfunction

  // valid is raised on a falling edge and held until the rising edge that accepts
  task automatic send_request(in_item_t r);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= r;
    do @(posedge clk); while (!in_ready);
    status_owed.push_back(apply_request(r));
  endtask

  task automatic hold_off(int n);
    repeat (n) @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk) in_valid <= 1'b0;
    while (status_owed.size() != 0) @(negedge clk);
  endtask

  task automatic write_reload(logic [10:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    reload_q = value;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t pick_request();
    int          roll;
    int          ch;
    logic [15:0] freq;
    logic [2:0]  cmd;
    roll = $urandom_range(0, 99);
    ch   = $urandom_range(0, NUM_CHANNELS - 1);
    freq = 16'($urandom_range(0, 65535));
    if (roll < 40) cmd = CMD_TICK;
    else if (roll < 52) cmd = CMD_OPEN;
    else if (roll < 60) cmd = CMD_CLOSE;
    else if (roll < 75) begin
      cmd = CMD_RATE;
      if ($urandom_range(0, 4) != 0) freq = 16'd1 << $urandom_range(1, 10);
    end else if (roll < 95) begin
      cmd = CMD_ACK;
      // aim most acknowledges at a channel with a pending event
      if ($urandom_range(0, 3) != 0) begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          if (ch_flag[(ch + k) % NUM_CHANNELS]) begin
            ch = (ch + k) % NUM_CHANNELS;
            break;
          end
        end
      end
    end else cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    return make_req(cmd, 3'(ch), freq);
  endfunction

  // receiver readiness, switching between randomly chosen patterns
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_ready <= (rx_left % 4 == 0);
      default:   out_ready <= (rx_left % 16 > 10);
    endcase
  end

  task automatic report_mismatch(string what, out_item_t want, out_item_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t %s: expected status %0d mask %02h, got status %0d mask %02h", $time, what,
               want.status, want.event_mask, got.status, got.event_mask);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (status_owed.size() == 0) begin
        report_mismatch("unexpected result", '0, out_item);
      end else begin
        want = status_owed.pop_front();
        if (out_item.status !== want.status || out_item.event_mask !== want.event_mask)
          report_mismatch("result mismatch", want, out_item);
      end
    end
  end

  // all closed: ticks do nothing, acknowledges find nothing, spare codes ignored
  task automatic test_idle_channels;
    send_request(make_req(CMD_TICK, 3'd0, 16'h0000));
    send_request(make_req(CMD_ACK, 3'd0, 16'h0000));
    send_request(make_req(CMD_SPARE_LO, 3'd3, 16'h0000));
    send_request(make_req(CMD_SPARE_HI, 3'd6, 16'hffff));
    drain();
  endtask

  // rejected rates, then valid rates that reopen closed channels at count -1
  task automatic test_rate_requests;
    send_request(make_req(CMD_RATE, 3'd1, 16'h0000));
    send_request(make_req(CMD_RATE, 3'd1, 16'h0003));
    send_request(make_req(CMD_RATE, 3'd1, 16'h0800));
    send_request(make_req(CMD_RATE, 3'd1, 16'hffff));
    send_request(make_req(CMD_RATE, 3'd1, 16'h0400));
    send_request(make_req(CMD_RATE, 3'd2, 16'h0002));
    send_request(make_req(CMD_TICK, 3'd7, 16'h0000));
    drain();
  endtask

  // reload at one, zero and its largest value
  task automatic test_reload_extremes;
    write_reload(11'd1);
    send_request(make_req(CMD_OPEN, 3'd3, 16'h0000));
    send_request(make_req(CMD_TICK, 3'd0, 16'h0000));
    send_request(make_req(CMD_TICK, 3'd0, 16'h0000));
    send_request(make_req(CMD_ACK, 3'd3, 16'h0000));
    send_request(make_req(CMD_ACK, 3'd3, 16'h0000));
    send_request(make_req(CMD_CLOSE, 3'd1, 16'h0000));
    write_reload(11'd0);
    send_request(make_req(CMD_OPEN, 3'd4, 16'h0000));
    send_request(make_req(CMD_TICK, 3'd0, 16'h0000));
    write_reload(11'd2047);
    send_request(make_req(CMD_OPEN, 3'd5, 16'h0000));
    send_request(make_req(CMD_RATE, 3'd5, 16'h0400));
    send_request(make_req(CMD_TICK, 3'd0, 16'h0000));
    send_request(make_req(CMD_TICK, 3'd0, 16'h0000));
    send_request(make_req(CMD_TICK, 3'd0, 16'h0000));
    drain();
  endtask

  // bursts of random requests with random gaps, now and then a full drain
  task automatic test_random_traffic(logic [10:0] reload, int n);
    int burst_left;
    burst_left = 0;
    write_reload(reload);
    for (int k = 0; k < n; k++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 24) == 0) drain();
        else if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end
      send_request(pick_request());
      burst_left--;
    end
    drain();
  endtask

  initial begin
    reload_q = RELOAD_RESET;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ch_open[i]  = 1'b0;
      ch_rate[i]  = '0;
      ch_count[i] = COUNT_IDLE;
      ch_flag[i]  = 1'b0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_idle_channels();
    test_rate_requests();
    test_reload_extremes();
    test_random_traffic(RELOAD_RESET, 150);
    test_random_traffic(11'd1, 150);
    test_random_traffic(11'd2047, 150);
    test_random_traffic(11'd0, 100);
    for (int p = 0; p < 3; p++) test_random_traffic(11'($urandom_range(2, 40)), 130);
    test_random_traffic(11'($urandom_range(1, 2047)), 100);

    drain();
    repeat (NUM_CHANNELS + 4) @(negedge clk);
    if (errors == 0 && status_owed.size() == 0) begin
      $display("multichannel_virtual_tick_divider_tb: done, clean");
    end else begin
      $display("multichannel_virtual_tick_divider_tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
design/mvtd_pkg.sv
design/mvtd_out_reg.sv
design/multichannel_virtual_tick_divider.sv
dv/multichannel_virtual_tick_divider_tb.sv
